// ===== hw/rtl/dost_pkg.sv =====
// Package for the directory offset subvolume transform.
// Word types, queue entry format and shared constants; no dependencies.
`default_nettype none
package dost_pkg;

  localparam int CFG_W = 11;
  localparam int IDX_W = 10;
  localparam int OFS_W = 64;
  localparam logic [CFG_W-1:0] MAX_LEAVES = 11'd1024;

  // Front-to-back queue
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = 2;

  // Divider pipeline: 4 quotient bits per stage
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES = OFS_W / BITS_PER_STAGE;

  // Result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW = 1;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  // How the back end finishes an entry
  typedef enum logic [1:0] {
    K_ENC = 2'd0,  // val holds the packed offset
    K_DEC = 2'd1,  // idx and val hold the decoded pair
    K_DIV = 2'd2   // val / n and val % n still to be done
  } kind_t;

  typedef struct packed {
    logic [0:0]       opcode;
    logic [OFS_W-1:0] offset;
    logic [IDX_W-1:0] leaf_id;
  } item_t;

  typedef struct packed {
    logic [OFS_W-1:0] transformed_offset;
    logic [IDX_W-1:0] subvol_index;
    logic [OFS_W-1:0] original_offset;
  } result_t;

  typedef struct packed {
    kind_t            kind;
    logic [OFS_W-1:0] val;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] n;
  } entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dost_front.sv =====
// Front end: leaf count register, item classification and the entry queue.
// Depends on dost_pkg.
`default_nettype none
module dost_front import dost_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             push,
  output logic                  full,
  input  wire item_t            item,
  output logic                  head_valid,
  output entry_t                head,
  input  wire logic             take
);

  logic [CFG_W-1:0] leaf_count;
  logic [CFG_W-1:0] n;
  logic [3:0]       b;
  logic [OFS_W-1:0] hi_mask;
  logic [OFS_W-1:0] x;
  logic             is_hi;
  entry_t           ent;
  logic [OFS_W+CFG_W-1:0] prod;

  entry_t           mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_AW:0]   count;
  logic             wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= CFG_W'(1);
    end else if (cfg_we) begin
      leaf_count <= cfg_data;
    end
  end

  always_comb begin
    if (leaf_count == '0) begin
      n = CFG_W'(1);
    end else if (leaf_count > MAX_LEAVES) begin
      n = MAX_LEAVES;
    end else begin
      n = leaf_count;
    end
    // bits needed to count n values
    b = '0;
    for (int k = 0; k < CFG_W; k++) begin
      if ((CFG_W'(1) << k) < n) b = b + 4'd1;
    end
  end

  assign x       = item.offset;
  assign hi_mask = {OFS_W{1'b1}} << b;
  assign is_hi   = (x >> (6'd62 - 6'(b))) != '0;
  assign prod    = x * n;

  always_comb begin
    ent.n   = n;
    ent.idx = '0;
    ent.val = x;
    if (item.opcode == OP_ENCODE) begin
      ent.kind = K_ENC;
      if (x == '1 || x == '0 || n == CFG_W'(1)) begin
        ent.val = x;
      end else if (is_hi) begin
        ent.val = (OFS_W'(1) << 62) | ((x >> 1) & hi_mask) | OFS_W'(item.leaf_id);
      end else begin
        ent.val = prod[OFS_W-1:0] + OFS_W'(item.leaf_id);
      end
    end else if (n == CFG_W'(1)) begin
      ent.kind = K_DEC;
    end else if (x[62]) begin
      ent.kind = K_DEC;
      ent.idx  = IDX_W'(x & ~hi_mask);
      ent.val  = ((x & ~(OFS_W'(1) << 62)) & hi_mask) << 1;
    end else begin
      ent.kind = K_DIV;
    end
  end

  assign full       = (count == (FQ_AW+1)'(FQ_DEPTH));
  assign wr         = push && !full;
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (take) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (FQ_AW+1)'(wr) - (FQ_AW+1)'(take);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dost_back.sv =====
// Back end: pipelined divide by the leaf count and the result queue.
// Depends on dost_pkg.
`default_nettype none
module dost_back import dost_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire entry_t head,
  output logic      take,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  typedef struct packed {
    entry_t           e;
    logic [IDX_W-1:0] rem;
  } stage_t;

  function automatic stage_t div_step(stage_t s);
    stage_t           r;
    logic [IDX_W:0]   t;
    r = s;
    if (s.e.kind == K_DIV) begin
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        t = {r.rem, r.e.val[OFS_W-1]};
        r.e.val = {r.e.val[OFS_W-2:0], 1'b0};
        if (t >= r.e.n) begin
          r.e.val[0] = 1'b1;
          t = t - r.e.n;
        end
        r.rem = t[IDX_W-1:0];
      end
    end
    return r;
  endfunction

  stage_t st [DIV_STAGES];
  logic   st_valid [DIV_STAGES];
  stage_t first_in;
  logic   adv;

  result_t           oq [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wr;
  logic [OQ_AW-1:0]  oq_rd;
  logic [OQ_AW:0]    oq_count;
  logic              oq_full;
  logic              oq_push;
  logic              oq_pop;
  result_t           fin;

  assign oq_full = (oq_count == (OQ_AW+1)'(OQ_DEPTH));
  // whole pipe holds only when its last stage cannot drain
  assign adv     = !(st_valid[DIV_STAGES-1] && oq_full);
  assign take    = adv && head_valid;

  assign first_in.e   = head;
  assign first_in.rem = '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= div_step(first_in);
      for (int i = 1; i < DIV_STAGES; i++) st[i] <= div_step(st[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_STAGES; i++) st_valid[i] <= 1'b0;
    end else if (adv) begin
      st_valid[0] <= head_valid;
      for (int i = 1; i < DIV_STAGES; i++) st_valid[i] <= st_valid[i-1];
    end
  end

  always_comb begin
    fin = '0;
    unique case (st[DIV_STAGES-1].e.kind)
      K_ENC: fin.transformed_offset = st[DIV_STAGES-1].e.val;
      K_DEC: begin
        fin.subvol_index    = st[DIV_STAGES-1].e.idx;
        fin.original_offset = st[DIV_STAGES-1].e.val;
      end
      K_DIV: begin
        fin.subvol_index    = st[DIV_STAGES-1].rem;
        fin.original_offset = st[DIV_STAGES-1].e.val;
      end
      default: fin = '0;
    endcase
  end

  assign oq_push = adv && st_valid[DIV_STAGES-1];
  assign empty   = (oq_count == '0);
  assign oq_pop  = pop && !empty;
  assign result  = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) oq_wr <= oq_wr + 1'b1;
      if (oq_pop) oq_rd <= oq_rd + 1'b1;
      oq_count <= oq_count + (OQ_AW+1)'(oq_push) - (OQ_AW+1)'(oq_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dir_offset_subvol_transform.sv =====
// Top level of the directory offset subvolume transform.
// Depends on dost_pkg, dost_front and dost_back.
//
// Accepts one word per cycle while full is low and returns one result per
// word, in order. The encode product and large-offset masking are done as
// the word is queued; every word then passes a 16-stage divider (4 quotient
// bits per stage) before it reaches the result queue. A 4-entry queue sits
// between classification and the divider, and a 2-entry queue holds
// finished results. Write leaf_count only while no word is in flight.
`default_nettype none
module dir_offset_subvol_transform import dost_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             push,
  output logic                  full,
  input  wire item_t            item,
  output logic                  empty,
  input  wire logic             pop,
  output result_t               result
);

  logic   head_valid;
  entry_t head;
  logic   take;

  dost_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .item       (item),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  dost_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  a_take_has_head: assert property (@(posedge clk) disable iff (rst)
    take |-> head_valid)
    else $error("entry taken from empty queue");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> empty && !full && !head_valid)
    else $error("queues not clear after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule
`default_nettype wire

// ===== verif/dir_offset_subvol_transform_tb.sv =====
// Testbench for dir_offset_subvol_transform: directed and random encode/decode words,
// checked in order against a predictor of the offset packing. Depends on dost_pkg.
`default_nettype none
module dir_offset_subvol_transform_tb;
  import dost_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class offset_scoreboard;
    result_t pending[$];
    logic [CFG_W-1:0] leaves_reg;
    int mismatches;

    function new();
      leaves_reg = 11'd1;
      mismatches = 0;
    endfunction

    function result_t transform(item_t it);
      result_t r;
      logic [63:0] n, lowmask, hi, x;
      int b;
      n = {53'd0, leaves_reg};
      if (n == 0) n = 1;
      if (n > MAX_LEAVES) n = MAX_LEAVES;
      b = 0;
      while ((64'd1 << b) < n && b < 63) b++;
      lowmask = ~64'd0 << b;
      x = it.offset;
      r = '0;
      if (opcode_t'(it.opcode) == OP_ENCODE) begin
        if (x == ~64'd0) r.transformed_offset = ~64'd0;
        else if (x == 0) r.transformed_offset = 0;
        else if (n == 1) r.transformed_offset = x;
        else begin
          hi = ~((~64'd0 >> 1) >> (b + 1));
          if ((x & hi) != 0)
            r.transformed_offset = (64'd1 << 62) | ((x >> 1) & lowmask) | it.leaf_id;
          else
            r.transformed_offset = x * n + it.leaf_id;
        end
      end else begin
        if (n == 1) r.original_offset = x;
        else if (x[62]) begin
          r.subvol_index = IDX_W'(x & ~lowmask);
          r.original_offset = ((x & ~(64'd1 << 62)) & lowmask) << 1;
        end else begin
          r.subvol_index = IDX_W'(x % n);
          r.original_offset = x / n;
        end
      end
      return r;
    endfunction

    function void note_word(item_t it);
      pending.push_back(transform(it));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.transformed_offset !== exp.transformed_offset ||
          got.subvol_index !== exp.subvol_index ||
          got.original_offset !== exp.original_offset) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp t=%h i=%0d o=%h got t=%h i=%0d o=%h",
                   exp.transformed_offset, exp.subvol_index, exp.original_offset,
                   got.transformed_offset, got.subvol_index, got.original_offset);
      end
    endfunction
  endclass

  logic clk, rst, cfg_we, push, pop, full, empty;
  logic [CFG_W-1:0] cfg_data;
  item_t item;
  result_t result;
  offset_scoreboard sb;
  int send_idle_pct, recv_stall_pct, hold_cycles;
  longint cycles;

  dir_offset_subvol_transform u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data), .push(push), .full(full),
    .item(item), .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1; cfg_we = 0; cfg_data = '0; push = 0; pop = 0; item = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
  end

  // receiver: pops at random, or holds off for a counted stretch
  always @(posedge clk) begin
    if (rst) pop <= 0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 0;
    end else pop <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && pop && !empty) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycles <= rst ? 0 : cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = v >> $urandom_range(63);
      1: v = v | (64'd1 << 62);
      2: v = v >> (12 + $urandom_range(8));
      3: v = v & ~(64'd1 << 62);
      default: ;
    endcase
    return v;
  endfunction

  // presents one word and holds it while full reads high; push stays high afterwards
  task automatic send_word(logic [0:0] op, logic [63:0] ofs, logic [IDX_W-1:0] cid);
    item_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(posedge clk);
    end
    w.opcode = op; w.offset = ofs; w.leaf_id = cid;
    push <= 1;
    item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_word(w);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_leaves(logic [CFG_W-1:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.leaves_reg = v;
  endtask

  task automatic random_words(int count);
    logic [CFG_W-1:0] lc;
    for (int i = 0; i < count; i++) begin
      lc = sb.leaves_reg;
      send_word(1'($urandom_range(1)), rand64(),
                ($urandom_range(3) == 0 || lc == 0) ? IDX_W'($urandom) :
                IDX_W'($urandom_range((lc > 1024 ? 1024 : lc) - 1)));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings[8];
    sb = new();
    settings = '{11'd2, 11'd1024, 11'd0, 11'd2047, 11'd3, 11'd1000, 11'd17, 11'd1};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: pass-through at reset, then extremes at several leaf counts
    send_word(OP_ENCODE, 64'd12345, 10'd3);
    send_word(OP_DECODE, ~64'd0, 10'd0);
    drain();
    set_leaves(11'd1024);
    send_word(OP_ENCODE, ~64'd0, 10'd5);
    send_word(OP_ENCODE, 64'd0, 10'd5);
    send_word(OP_ENCODE, 64'd1, 10'd1023);
    send_word(OP_ENCODE, 64'h0000_FFFF_FFFF_FFFF, 10'd1023);
    send_word(OP_ENCODE, 64'h8000_0000_0000_0001, 10'd1023);
    send_word(OP_ENCODE, 64'h0010_0000_0000_0000, 10'd7);
    send_word(OP_DECODE, 64'h4000_0000_0000_03FF, 10'd0);
    send_word(OP_DECODE, ~64'd0, 10'd0);
    send_word(OP_DECODE, 64'd0, 10'd0);
    send_word(OP_DECODE, 64'h3FFF_FFFF_FFFF_FFFF, 10'd0);
    drain();
    set_leaves(11'd3);
    send_word(OP_ENCODE, 64'd100, 10'd1023);
    send_word(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFE, 10'd2);
    send_word(OP_DECODE, 64'd301, 10'd0);
    send_word(OP_DECODE, 64'h4000_0000_0000_0003, 10'd0);
    drain();
    // random phases over the idle settings and leaf counts
    for (int p = 0; p < 8; p++) begin
      set_leaves(settings[p]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 70; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      if (p == 4) begin
        hold_cycles = 200;
        send_idle_pct = 0;
      end
      random_words(72);
      drain();
    end
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
